// ===== hdl/range_sum_tree_engine_defines.svh =====
// ----------------------------------------------------------------------------
// range sum tree engine assertion macros
// shared property forms for the engine checks
// ----------------------------------------------------------------------------
`ifndef RANGE_SUM_TREE_ENGINE_DEFINES_SVH
`define RANGE_SUM_TREE_ENGINE_DEFINES_SVH

// same-cycle implication, ignored while reset is high
`define RSTE_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked through reset as well
`define RSTE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/rste_pkg.sv =====
// ----------------------------------------------------------------------------
// rste_pkg
// shared types and constants of the range sum tree engine
// ----------------------------------------------------------------------------
package rste_pkg;

   localparam int unsigned MAX_ELEMENTS = 1024;
   localparam int unsigned IDX_W        = 10;
   localparam int unsigned CNT_W        = 11;
   localparam int unsigned NODE_W       = 11;
   localparam int unsigned NODE_DEPTH   = 2048;
   localparam int unsigned VAL_W        = 32;
   localparam int unsigned SUM_W        = 42;
   localparam int unsigned DELTA_W      = 33;

   typedef enum logic [1:0] {
      CMD_WRITE  = 2'd0,
      CMD_QUERY  = 2'd1,
      CMD_CLEAR  = 2'd2,
      CMD_UNUSED = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      OP_WRITE  = 2'd0,
      OP_QUERY  = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_REJECT = 2'd3
   } op_type;

   typedef struct packed {
      op_type                   op;
      logic [IDX_W-1:0]         lo;
      logic [IDX_W-1:0]         hi;
      logic signed [VAL_W-1:0]  value;
      logic [IDX_W-1:0]         top;
   } job_type;

endpackage

// ===== hdl/range_sum_tree_engine.sv =====
// ----------------------------------------------------------------------------
// range_sum_tree_engine
// segment tree of partial sums with point writes and range sum queries
// ----------------------------------------------------------------------------
// The engine keeps up to 1024 signed 32-bit elements and a tree of 42-bit
// partial sums in two single-port memories. Each request gives exactly one
// response. A write reads and then writes its element, then reads and writes
// every node on the path from the root down to the leaf (depth up to 10); a
// query visits the nodes on the split path and on the two boundary paths; a
// rejected or unused command goes straight to the response. Clear sweeps the
// node memory and the element memory, one node a cycle. After reset the same
// sweep runs and req_tready stays low until it is done. Up to three requests
// can sit in the front register and the job queue while the walker is busy,
// and a finished response waits in its own register. Write element_count only
// while idle, and clear after changing it.
// ----------------------------------------------------------------------------
`include "range_sum_tree_engine_defines.svh"

module range_sum_tree_engine import rste_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   // request channel
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [55:0]      req_tdata,   // low_index, high_index, value, zero pad
   input  logic [1:0]       req_tuser,   // command
   // response channel
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [47:0]      rsp_tdata,   // range_sum, zero pad
   output logic             rsp_tuser,   // status
   // element count register
   input  logic             csr_wr_en,
   input  logic [CNT_W-1:0] csr_wr_data
);

   logic [CNT_W-1:0] element_count_ff;
   logic             init_busy;
   logic             front_valid;
   job_type          front_job;
   logic             q_full, q_not_empty, q_pop;
   job_type          q_head;

   // element count register, reset to the full array
   always_ff @(posedge clock) begin
      if (reset) begin
         element_count_ff <= CNT_W'(MAX_ELEMENTS);
      end else if (csr_wr_en) begin
         element_count_ff <= csr_wr_data;
      end
   end

   // front: accept and check each request
   rste_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .element_count (element_count_ff),
      .init_busy     (init_busy),
      .q_full        (q_full),
      .job_valid     (front_valid),
      .job           (front_job)
   );

   // queue so the front keeps taking requests while the walker is busy
   rste_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_job  (front_job),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   // back: tree walks over the node memory
   rste_back u_back (
      .clock      (clock),
      .reset      (reset),
      .job_valid  (q_not_empty),
      .job        (q_head),
      .pop        (q_pop),
      .init_busy  (init_busy),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // no request is taken while the post-reset sweep runs
   `RSTE_ASSERT_NEXT(a_reset_blocks_req, reset, !req_tready, "request ready during init sweep")
   // an error response never carries a sum
   `RSTE_ASSERT_NOW(a_err_zero_sum, rsp_tvalid && rsp_tuser, rsp_tdata == 48'd0, "error with sum")
   // the walker only takes a job that is waiting in the queue
   `RSTE_ASSERT_NOW(a_pop_nonempty, q_pop, q_not_empty, "job popped from empty queue")

endmodule

// ===== hdl/rste_front.sv =====
// ----------------------------------------------------------------------------
// rste_front
// takes requests, checks indices against the element count, queues jobs
// ----------------------------------------------------------------------------
module rste_front import rste_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [55:0]      req_tdata,
   input  logic [1:0]       req_tuser,
   input  logic [CNT_W-1:0] element_count,
   input  logic             init_busy,
   input  logic             q_full,
   output logic             job_valid,
   output job_type          job
);

   logic             job_valid_ff, job_valid_in;
   job_type          job_ff, job_in;
   logic [CNT_W-1:0] n_sat;
   logic [IDX_W-1:0] top;
   logic             n_zero;
   logic [IDX_W-1:0] lo, hi;
   logic             accept;

   assign n_sat  = (element_count > CNT_W'(MAX_ELEMENTS)) ? CNT_W'(MAX_ELEMENTS)
                                                         : element_count;
   assign n_zero = (n_sat == '0);
   assign top    = IDX_W'(n_sat - CNT_W'(1));
   assign lo     = req_tdata[9:0];
   assign hi     = req_tdata[19:10];

   assign req_tready = (!job_valid_ff || !q_full) && !init_busy;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      job_in       = job_ff;
      job_valid_in = job_valid_ff && q_full;
      if (accept) begin
         job_valid_in = 1'b1;
         job_in.lo    = lo;
         job_in.hi    = hi;
         job_in.value = req_tdata[51:20];
         job_in.top   = top;
         unique case (cmd_type'(req_tuser))
            CMD_WRITE: job_in.op = (!n_zero && lo <= top) ? OP_WRITE : OP_REJECT;
            CMD_QUERY: job_in.op = (!n_zero && hi <= top && lo <= hi) ? OP_QUERY
                                                                      : OP_REJECT;
            CMD_CLEAR: job_in.op = OP_CLEAR;
            default:   job_in.op = OP_REJECT;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
      end
      job_ff <= job_in;
   end

   assign job_valid = job_valid_ff;
   assign job       = job_ff;

endmodule

// ===== hdl/rste_fifo.sv =====
// ----------------------------------------------------------------------------
// rste_fifo
// two-entry job queue between the front and the tree walker
// ----------------------------------------------------------------------------
module rste_fifo import rste_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output logic    full,
   output logic    not_empty,
   output job_type head
);

   job_type    entry_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic       do_push, do_pop;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign head      = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) wr_ptr_ff <= !wr_ptr_ff;
         if (do_pop)  rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + 2'(do_push) - 2'(do_pop);
      end
      if (do_push) entry_ff[wr_ptr_ff] <= push_job;
   end

endmodule

// ===== hdl/rste_back.sv =====
// ----------------------------------------------------------------------------
// rste_back
// tree walker: element and node memories, write and query walks, clearing
// ----------------------------------------------------------------------------
module rste_back import rste_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        job_valid,
   input  job_type     job,
   output logic        pop,
   output logic        init_busy,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,
   output logic        rsp_tuser
);

   typedef enum logic [3:0] {
      S_INIT, S_CLEAR, S_IDLE, S_W_ELEM, S_W_DELTA, S_W_RD, S_W_WR,
      S_Q_SPLIT, S_Q_LEFT, S_Q_RIGHT, S_Q_END, S_DONE
   } state_type;

   logic [SUM_W-1:0] node_mem [NODE_DEPTH];
   logic [VAL_W-1:0] elem_mem [MAX_ELEMENTS];

   state_type                 state_ff, state_in;
   job_type                   job_ff, job_in;
   logic [NODE_W-1:0]         node_ff, node_in, rnode_ff, rnode_in;
   logic [IDX_W-1:0]          l_ff, l_in, h_ff, h_in, rl_ff, rl_in, rh_ff, rh_in;
   logic signed [DELTA_W-1:0] delta_ff, delta_in;
   logic [SUM_W-1:0]          acc_ff, acc_in;
   logic                      pend_ff, pend_in;
   logic [NODE_W-1:0]         cnt_ff, cnt_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [SUM_W-1:0]          rsp_sum_ff, rsp_sum_in;
   logic                      rsp_err_ff, rsp_err_in;

   logic [SUM_W-1:0]  node_rd_ff;
   logic [VAL_W-1:0]  elem_rd_ff;
   logic              node_we, elem_we;
   logic [NODE_W-1:0] node_addr;
   logic [SUM_W-1:0]  node_wdata;
   logic [IDX_W-1:0]  elem_addr;
   logic [VAL_W-1:0]  elem_wdata;

   logic [IDX_W-1:0]  mid;
   logic [NODE_W-1:0] left_child, right_child;

   assign mid         = l_ff + ((h_ff - l_ff) >> 1);
   assign left_child  = {node_ff[NODE_W-2:0], 1'b1};
   assign right_child = {node_ff[NODE_W-2:0], 1'b0} + NODE_W'(2);

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      node_in      = node_ff;
      l_in         = l_ff;
      h_in         = h_ff;
      rnode_in     = rnode_ff;
      rl_in        = rl_ff;
      rh_in        = rh_ff;
      delta_in     = delta_ff;
      acc_in       = pend_ff ? acc_ff + node_rd_ff : acc_ff;
      pend_in      = 1'b0;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_sum_in   = rsp_sum_ff;
      rsp_err_in   = rsp_err_ff;
      pop          = 1'b0;
      node_we      = 1'b0;
      node_addr    = node_ff;
      node_wdata   = node_rd_ff + {{(SUM_W-DELTA_W){delta_ff[DELTA_W-1]}}, delta_ff};
      elem_we      = 1'b0;
      elem_addr    = job_ff.lo;
      elem_wdata   = job_ff.value;

      unique case (state_ff) inside
         S_INIT, S_CLEAR: begin
            node_we    = 1'b1;
            node_addr  = cnt_ff;
            node_wdata = '0;
            elem_we    = !cnt_ff[NODE_W-1];
            elem_addr  = cnt_ff[IDX_W-1:0];
            elem_wdata = '0;
            cnt_in     = cnt_ff + NODE_W'(1);
            if (cnt_ff == NODE_W'(NODE_DEPTH - 1)) begin
               state_in = (state_ff == S_INIT) ? S_IDLE : S_DONE;
            end
         end
         S_IDLE: begin
            if (job_valid) begin
               pop     = 1'b1;
               job_in  = job;
               node_in = '0;
               l_in    = '0;
               h_in    = job.top;
               acc_in  = '0;
               cnt_in  = '0;
               unique case (job.op)
                  OP_WRITE: state_in = S_W_ELEM;
                  OP_QUERY: state_in = S_Q_SPLIT;
                  OP_CLEAR: state_in = S_CLEAR;
                  default:  state_in = S_DONE;
               endcase
            end
         end
         S_W_ELEM: state_in = S_W_DELTA;
         S_W_DELTA: begin
            delta_in = DELTA_W'(job_ff.value) - DELTA_W'($signed(elem_rd_ff));
            elem_we  = 1'b1;
            state_in = S_W_RD;
         end
         S_W_RD: state_in = S_W_WR;
         S_W_WR: begin
            node_we = 1'b1;
            if (l_ff == h_ff) begin
               state_in = S_DONE;
            end else begin
               state_in = S_W_RD;
               if (job_ff.lo <= mid) begin
                  node_in = left_child;
                  h_in    = mid;
               end else begin
                  node_in = right_child;
                  l_in    = mid + IDX_W'(1);
               end
            end
         end
         S_Q_SPLIT: begin
            if (job_ff.lo <= l_ff && job_ff.hi >= h_ff) begin
               pend_in  = 1'b1;
               state_in = S_Q_END;
            end else if (job_ff.hi <= mid) begin
               node_in = left_child;
               h_in    = mid;
            end else if (job_ff.lo > mid) begin
               node_in = right_child;
               l_in    = mid + IDX_W'(1);
            end else begin
               node_in  = left_child;
               h_in     = mid;
               rnode_in = right_child;
               rl_in    = mid + IDX_W'(1);
               rh_in    = h_ff;
               state_in = S_Q_LEFT;
            end
         end
         S_Q_LEFT: begin
            // left boundary path: right children are wholly inside
            if (job_ff.lo <= l_ff) begin
               pend_in  = 1'b1;
               node_in  = rnode_ff;
               l_in     = rl_ff;
               h_in     = rh_ff;
               state_in = S_Q_RIGHT;
            end else if (job_ff.lo <= mid) begin
               pend_in   = 1'b1;
               node_addr = right_child;
               node_in   = left_child;
               h_in      = mid;
            end else begin
               node_in = right_child;
               l_in    = mid + IDX_W'(1);
            end
         end
         S_Q_RIGHT: begin
            // right boundary path: left children are wholly inside
            if (job_ff.hi >= h_ff) begin
               pend_in  = 1'b1;
               state_in = S_Q_END;
            end else if (job_ff.hi > mid) begin
               pend_in   = 1'b1;
               node_addr = left_child;
               node_in   = right_child;
               l_in      = mid + IDX_W'(1);
            end else begin
               node_in = left_child;
               h_in    = mid;
            end
         end
         S_Q_END: state_in = S_DONE;
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_err_in   = (job_ff.op == OP_REJECT);
               rsp_sum_in   = (job_ff.op == OP_QUERY) ? acc_ff : '0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      job_ff     <= job_in;
      node_ff    <= node_in;
      l_ff       <= l_in;
      h_ff       <= h_in;
      rnode_ff   <= rnode_in;
      rl_ff      <= rl_in;
      rh_ff      <= rh_in;
      delta_ff   <= delta_in;
      acc_ff     <= acc_in;
      rsp_sum_ff <= rsp_sum_in;
      rsp_err_ff <= rsp_err_in;
   end

   always_ff @(posedge clock) begin
      if (node_we) node_mem[node_addr] <= node_wdata;
      node_rd_ff <= node_mem[node_addr];
   end

   always_ff @(posedge clock) begin
      if (elem_we) elem_mem[elem_addr] <= elem_wdata;
      elem_rd_ff <= elem_mem[elem_addr];
   end

   assign init_busy  = (state_ff == S_INIT);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_sum_ff};
   assign rsp_tuser  = rsp_err_ff;

endmodule
